// ===== design/vfcm_pkg.sv =====
// Shared types, widths and face tables for the voxel face cull mesher.
package vfcm_pkg;

  localparam int GRID_SIDE_DEF = 16;

  localparam int CMD_W    = 2;
  localparam int COORD_W  = 4;
  localparam int VERT_W   = 5;
  localparam int FACE_W   = 3;
  localparam int UV_W     = 2;
  localparam int INDEX_W  = 17;
  localparam int S_DATA_W = 16;
  localparam int S_USER_W = 2;
  localparam int M_DATA_W = 40;

  typedef enum logic [CMD_W-1:0] {
    CMD_SET   = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_START = 2'd2,
    CMD_MESH  = 2'd3
  } cmd_t;

  localparam logic [FACE_W-1:0] FACE_UP    = 3'd0;
  localparam logic [FACE_W-1:0] FACE_DOWN  = 3'd1;
  localparam logic [FACE_W-1:0] FACE_FWD   = 3'd2;
  localparam logic [FACE_W-1:0] FACE_RIGHT = 3'd3;
  localparam logic [FACE_W-1:0] FACE_BACK  = 3'd4;
  localparam logic [FACE_W-1:0] FACE_LEFT  = 3'd5;
  localparam logic [FACE_W-1:0] FACE_LAST  = FACE_LEFT;

  // corner offset {ox, oy, oz}
  function automatic logic [2:0] corner_ofs(input logic [FACE_W-1:0] face,
                                            input logic [1:0] corner);
    logic [3:0][2:0] row;
    case (face)
      FACE_UP:    row = {3'b110, 3'b111, 3'b011, 3'b010};
      FACE_DOWN:  row = {3'b001, 3'b101, 3'b100, 3'b000};
      FACE_FWD:   row = {3'b001, 3'b011, 3'b111, 3'b101};
      FACE_RIGHT: row = {3'b101, 3'b111, 3'b110, 3'b100};
      FACE_BACK:  row = {3'b100, 3'b110, 3'b010, 3'b000};
      FACE_LEFT:  row = {3'b000, 3'b010, 3'b011, 3'b001};
      default:    row = '0;
    endcase
    return row[corner];
  endfunction

  // texture coordinate {u, v} in halves
  function automatic logic [2*UV_W-1:0] tex_uv(input logic [FACE_W-1:0] face,
                                               input logic [1:0] corner);
    logic [3:0][2*UV_W-1:0] row;
    case (face)
      FACE_UP:   row = {4'b0010, 4'b0110, 4'b0101, 4'b0001};
      FACE_DOWN: row = {4'b0101, 4'b1001, 4'b1000, 4'b0100};
      default:   row = {4'b0001, 4'b0101, 4'b0100, 4'b0000};
    endcase
    return row[corner];
  endfunction

endpackage

// ===== design/voxel_face_cull_mesher_core.sv =====
// Voxel face cull mesher: occupancy memory, neighbor probe sequencer, vertex output.
// After reset a clearing pass writes every cell empty, one a cycle, GRID_SIDE^3 cells
// (4096 at the default side); s_tready stays low meanwhile.
// Set, clear and start complete on acceptance. A mesh command emits four vertices for each
// exposed face: six neighbor reads on the one read port, a drain and a scan state, then one
// vertex transfer per cycle while m_tready allows; one command in work, registered m_* stage.
module voxel_face_cull_mesher_core #(
  parameter int GRID_SIDE = vfcm_pkg::GRID_SIDE_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // cell_x[3:0], cell_y[7:4], cell_z[11:8], zero fill
  input  logic [vfcm_pkg::S_DATA_W-1:0] s_tdata,
  // command[1:0]
  input  logic [vfcm_pkg::S_USER_W-1:0] s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // vert_x[4:0], vert_y[9:5], vert_z[14:10], face_dir[17:15], tex_u[19:18],
  // tex_v[21:20], vertex_index[38:22], zero fill
  output logic [vfcm_pkg::M_DATA_W-1:0] m_tdata,
  output logic                          m_tlast
);
  import vfcm_pkg::*;

  localparam int CELL_COUNT = GRID_SIDE * GRID_SIDE * GRID_SIDE;
  localparam int AW   = $clog2(CELL_COUNT);
  localparam int CMPW = ($clog2(GRID_SIDE + 1) > 5) ? $clog2(GRID_SIDE + 1) : 5;
  localparam int IW   = AW + CMPW;
  localparam int NFACE = 6;

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_PROBE = 6'b000100,
    ST_DRAIN = 6'b001000,
    ST_SCAN  = 6'b010000,
    ST_EMIT  = 6'b100000
  } state_t;

  state_t state, state_next;

  logic             mem [CELL_COUNT];
  logic             we;
  logic [AW-1:0]    wa;
  logic             wd;
  logic [AW-1:0]    ra;
  logic             rd_data;
  logic             rd_live;
  logic             rd_out;
  logic [FACE_W-1:0] rd_face;

  logic [AW-1:0]    clr_addr;
  logic [COORD_W-1:0] cx, cy, cz;
  logic [FACE_W-1:0] pf;
  logic [NFACE-1:0] mask;
  logic [NFACE-1:0] mask_rest;
  logic [FACE_W-1:0] cur_face;
  logic [1:0]       corner;
  logic [INDEX_W-1:0] vcount;

  cmd_t             cmd;
  logic [COORD_W-1:0] in_x, in_y, in_z;
  logic             in_grid;
  logic             accept;
  logic [CMPW-1:0]  nx, ny, nz;
  logic             n_out;
  logic             out_load;
  logic [2:0]       ofs;
  logic [2*UV_W-1:0] uv;

  function automatic logic [AW-1:0] cell_index(input logic [CMPW-1:0] x,
                                               input logic [CMPW-1:0] y,
                                               input logic [CMPW-1:0] z);
    logic [IW-1:0] full;
    full = IW'(x) * IW'(GRID_SIDE * GRID_SIDE) + IW'(y) * IW'(GRID_SIDE) + IW'(z);
    return full[AW-1:0];
  endfunction

  function automatic logic [FACE_W-1:0] first_face(input logic [NFACE-1:0] m);
    logic [FACE_W-1:0] f;
    f = '0;
    for (int i = NFACE - 1; i >= 0; i--) begin
      if (m[i]) f = FACE_W'(i);
    end
    return f;
  endfunction

  assign cmd  = cmd_t'(s_tuser[CMD_W-1:0]);
  assign in_x = s_tdata[COORD_W-1:0];
  assign in_y = s_tdata[2*COORD_W-1:COORD_W];
  assign in_z = s_tdata[3*COORD_W-1:2*COORD_W];
  assign in_grid = (CMPW'(in_x) < CMPW'(GRID_SIDE)) && (CMPW'(in_y) < CMPW'(GRID_SIDE))
                && (CMPW'(in_z) < CMPW'(GRID_SIDE));

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_load = (state == ST_EMIT) && (!m_tvalid || m_tready);
  assign mask_rest = mask & ~(NFACE'(1) << cur_face);

  // neighbor of the probed face
  always_comb begin
    nx = CMPW'(cx);
    ny = CMPW'(cy);
    nz = CMPW'(cz);
    n_out = 1'b0;
    unique case (pf)
      FACE_UP:    ny = CMPW'(cy) + CMPW'(1);
      FACE_DOWN:  if (cy == '0) n_out = 1'b1; else ny = CMPW'(cy) - CMPW'(1);
      FACE_FWD:   nz = CMPW'(cz) + CMPW'(1);
      FACE_RIGHT: nx = CMPW'(cx) + CMPW'(1);
      FACE_BACK:  if (cz == '0) n_out = 1'b1; else nz = CMPW'(cz) - CMPW'(1);
      FACE_LEFT:  if (cx == '0) n_out = 1'b1; else nx = CMPW'(cx) - CMPW'(1);
      default: ;
    endcase
    if (nx >= CMPW'(GRID_SIDE) || ny >= CMPW'(GRID_SIDE) || nz >= CMPW'(GRID_SIDE)) begin
      n_out = 1'b1;
    end
    ra = cell_index(nx, ny, nz);
  end

  always_comb begin
    we = 1'b0;
    wa = clr_addr;
    wd = 1'b0;
    if (state == ST_CLEAR) begin
      we = 1'b1;
    end else if (accept && in_grid && (cmd == CMD_SET || cmd == CMD_CLEAR)) begin
      we = 1'b1;
      wa = cell_index(CMPW'(in_x), CMPW'(in_y), CMPW'(in_z));
      wd = (cmd == CMD_SET);
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_data <= mem[ra];
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (clr_addr == AW'(CELL_COUNT - 1)) state_next = ST_IDLE;
      ST_IDLE:  if (accept && cmd == CMD_MESH && in_grid) state_next = ST_PROBE;
      ST_PROBE: if (pf == FACE_LAST) state_next = ST_DRAIN;
      ST_DRAIN: state_next = ST_SCAN;
      ST_SCAN:  state_next = (mask == '0) ? ST_IDLE : ST_EMIT;
      ST_EMIT:  if (out_load && corner == 2'd3 && mask_rest == '0) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      rd_live  <= 1'b0;
      vcount   <= '0;
      pf       <= '0;
      mask     <= '0;
      cur_face <= '0;
      corner   <= '0;
    end else begin
      state   <= state_next;
      rd_live <= (state == ST_PROBE);
      if (state == ST_CLEAR) clr_addr <= clr_addr + AW'(1);
      if (accept) begin
        pf   <= '0;
        mask <= '0;
        if (cmd == CMD_START) vcount <= '0;
      end
      if (state == ST_PROBE) pf <= pf + FACE_W'(1);
      if (rd_live) mask[rd_face] <= rd_out | ~rd_data;
      if (state == ST_SCAN) begin
        cur_face <= first_face(mask);
        corner   <= '0;
      end
      if (out_load) begin
        vcount <= vcount + INDEX_W'(1);
        corner <= corner + 2'd1;
        if (corner == 2'd3) begin
          mask     <= mask_rest;
          cur_face <= first_face(mask_rest);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_face <= pf;
    rd_out  <= n_out;
    if (accept) begin
      cx <= in_x;
      cy <= in_y;
      cz <= in_z;
    end
  end

  assign ofs = corner_ofs(cur_face, corner);
  assign uv  = tex_uv(cur_face, corner);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {1'b0, vcount, uv[UV_W-1:0], uv[2*UV_W-1:UV_W], cur_face,
                  VERT_W'(cz) + VERT_W'(ofs[0]),
                  VERT_W'(cy) + VERT_W'(ofs[1]),
                  VERT_W'(cx) + VERT_W'(ofs[2])};
      m_tlast <= (corner == 2'd3) && (mask_rest == '0);
    end
  end

endmodule
